// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising edge of clk while out of reset.
`define XKS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define XKS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// Checks that a condition implies another in the same cycle.
`define XKS_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- design/xks_pkg.sv -----
package xks_pkg;

    // Input word kinds, carried on tuser.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_ABSORB = 2'd1,
        KIND_MIX    = 2'd2,
        KIND_DATA   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_DATA,
        ST_MIX_RD,
        ST_MIX_WR
    } state_t;

    // Source of the primary key memory read address.
    typedef enum logic [1:0] {
        RD_DATA,
        RD_ABSORB,
        RD_MIX
    } rd_src_t;

    // Source of the key memory write address and data.
    typedef enum logic {
        WR_ABSORB,
        WR_MIX
    } wr_src_t;

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_en;
        wr_src_t wr_src;
        logic    out_load;
        logic    mix_start;
        logic    mix_advance;
    } cmd_t;

    typedef struct packed {
        logic mix_elem_last;
        logic mix_round_last;
        logic out_free;
    } status_t;

    localparam logic [31:0] GOLDEN       = 32'h9E3779B9;
    localparam logic [7:0]  GOLDEN_LOW   = GOLDEN[7:0];
    localparam int          MIX_NEIGHBOR = 7;
    localparam int          ROTATE       = 3;

endpackage

// ----- design/xks_ram.sv -----
module xks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/xks_ctrl.sv -----
`include "assert_macros.svh"

module xks_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  xks_pkg::kind_t   in_kind,
    output logic             in_ready,
    output xks_pkg::cmd_t    cmd,
    input  xks_pkg::status_t sts
);

    xks_pkg::state_t state_reg;
    xks_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xks_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xks_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        xks_pkg::KIND_ABSORB: state_next = xks_pkg::ST_ABSORB;
                        xks_pkg::KIND_MIX:    state_next = xks_pkg::ST_MIX_RD;
                        xks_pkg::KIND_DATA:   state_next = xks_pkg::ST_DATA;
                        default:              state_next = xks_pkg::ST_IDLE;
                    endcase
                end
            end
            xks_pkg::ST_ABSORB: state_next = xks_pkg::ST_IDLE;
            xks_pkg::ST_DATA:
            begin
                if (sts.out_free)
                begin
                    state_next = xks_pkg::ST_IDLE;
                end
            end
            xks_pkg::ST_MIX_RD: state_next = xks_pkg::ST_MIX_WR;
            xks_pkg::ST_MIX_WR:
            begin
                if (sts.mix_elem_last && sts.mix_round_last)
                begin
                    state_next = xks_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = xks_pkg::ST_MIX_RD;
                end
            end
            default: state_next = xks_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.rd_src      = xks_pkg::RD_DATA;
        cmd.wr_src      = xks_pkg::WR_ABSORB;
        case (state_reg)
            xks_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    case (in_kind)
                        xks_pkg::KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        xks_pkg::KIND_ABSORB:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = xks_pkg::RD_ABSORB;
                        end
                        xks_pkg::KIND_MIX:
                        begin
                            cmd.mix_start = 1'b1;
                        end
                        default:
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = xks_pkg::RD_DATA;
                        end
                    endcase
                end
            end
            xks_pkg::ST_ABSORB:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = xks_pkg::WR_ABSORB;
            end
            xks_pkg::ST_DATA:
            begin
                cmd.out_load = sts.out_free;
            end
            xks_pkg::ST_MIX_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = xks_pkg::RD_MIX;
            end
            xks_pkg::ST_MIX_WR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_src      = xks_pkg::WR_MIX;
                cmd.mix_advance = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `XKS_ASSERT_NEXT(a_mix_starts, (state_reg == xks_pkg::ST_IDLE && in_valid && in_kind == xks_pkg::KIND_MIX), (state_reg == xks_pkg::ST_MIX_RD), "mix word did not start the mix sequence")
    `XKS_ASSERT_NEXT(a_mix_wr_next, (state_reg == xks_pkg::ST_MIX_WR), (state_reg == xks_pkg::ST_MIX_RD || state_reg == xks_pkg::ST_IDLE), "mix write followed by an unexpected state")
    `XKS_ASSERT_NEXT(a_mix_done, (state_reg == xks_pkg::ST_MIX_WR && !(sts.mix_elem_last && sts.mix_round_last)), (state_reg == xks_pkg::ST_MIX_RD), "mix ended before its last round")

endmodule

// ----- design/xks_datapath.sv -----
`include "assert_macros.svh"

module xks_datapath #(
    parameter int KEY_BYTES  = 32,
    parameter int MIX_ROUNDS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_value,
    input  logic             in_last,
    input  xks_pkg::cmd_t    cmd,
    output xks_pkg::status_t sts,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    localparam int AW = $clog2(KEY_BYTES);
    localparam int RW = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
    localparam logic [AW-1:0] IDX_LAST   = AW'(KEY_BYTES - 1);
    localparam logic [RW-1:0] ROUND_LAST = RW'(MIX_ROUNDS - 1);
    localparam logic [AW:0]   NB_OFFSET  = (AW + 1)'(xks_pkg::MIX_NEIGHBOR);
    localparam logic [AW:0]   KEY_SIZE   = (AW + 1)'(KEY_BYTES);

    logic [7:0]           value_reg;
    logic                 last_reg;
    logic [KEY_BYTES-1:0] valid_reg;
    logic [KEY_BYTES-1:0] valid_next;
    logic                 rd_valid_a_reg;
    logic                 rd_valid_b_reg;
    logic [AW-1:0]        absorb_pos_reg;
    logic [AW-1:0]        absorb_pos_next;
    logic [AW-1:0]        key_idx_reg;
    logic [AW-1:0]        key_idx_next;
    logic [15:0]          byte_pos_reg;
    logic [15:0]          byte_pos_next;
    logic [7:0]           counter_reg;
    logic [7:0]           counter_next;
    logic [AW-1:0]        mix_idx_reg;
    logic [AW-1:0]        mix_idx_next;
    logic [RW-1:0]        mix_round_reg;
    logic [RW-1:0]        mix_round_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic [AW:0]   nb_sum;
    logic [AW-1:0] mix_nb;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata_a;
    logic [7:0]    rdata_b;
    logic [7:0]    key_a;
    logic [7:0]    key_b;
    logic [7:0]    key_rot;
    logic [15:0]   pos_prod;
    logic [7:0]    keystream;
    logic          out_free;

    // Neighbor entry of the mix, (i + 7) mod N.
    assign nb_sum = {1'b0, mix_idx_reg} + NB_OFFSET;
    assign mix_nb = (nb_sum >= KEY_SIZE) ? AW'(nb_sum - KEY_SIZE) : nb_sum[AW-1:0];

    always_comb
    begin
        case (cmd.rd_src)
            xks_pkg::RD_ABSORB: raddr_a = absorb_pos_reg;
            xks_pkg::RD_MIX:    raddr_a = mix_idx_reg;
            default:            raddr_a = key_idx_reg;
        endcase
    end

    // Entries never written since the last clear read as zero.
    assign key_a   = rd_valid_a_reg ? rdata_a : 8'h00;
    assign key_b   = rd_valid_b_reg ? rdata_b : 8'h00;
    assign key_rot = {key_a[7-xks_pkg::ROTATE:0], key_a[7:8-xks_pkg::ROTATE]};

    always_comb
    begin
        case (cmd.wr_src)
            xks_pkg::WR_MIX:
            begin
                waddr = mix_idx_reg;
                wdata = key_rot ^ key_b;
            end
            default:
            begin
                waddr = absorb_pos_reg;
                wdata = key_a ^ value_reg;
            end
        endcase
    end

    xks_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES)
    ) u_key_ram (
        .clk     (clk),
        .we      (cmd.wr_en),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (cmd.rd_en),
        .raddr_a (raddr_a),
        .raddr_b (mix_nb),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Only the low byte of pos * golden ratio matters, so an 8x8 product suffices.
    assign pos_prod  = {8'h00, byte_pos_reg[7:0]} * {8'h00, xks_pkg::GOLDEN_LOW};
    assign keystream = counter_reg ^ pos_prod[7:0];

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        valid_next      = valid_reg;
        absorb_pos_next = absorb_pos_reg;
        key_idx_next    = key_idx_reg;
        byte_pos_next   = byte_pos_reg;
        counter_next    = counter_reg;
        mix_idx_next    = mix_idx_reg;
        mix_round_next  = mix_round_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.clear)
        begin
            valid_next      = '0;
            absorb_pos_next = '0;
            key_idx_next    = '0;
            byte_pos_next   = '0;
            counter_next    = '0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[waddr] = 1'b1;
            if (cmd.wr_src == xks_pkg::WR_ABSORB)
            begin
                absorb_pos_next = (absorb_pos_reg == IDX_LAST) ? '0 : absorb_pos_reg + AW'(1);
            end
        end

        if (cmd.mix_start)
        begin
            mix_idx_next   = '0;
            mix_round_next = '0;
        end
        else if (cmd.mix_advance)
        begin
            if (mix_idx_reg == IDX_LAST)
            begin
                mix_idx_next   = '0;
                mix_round_next = mix_round_reg + RW'(1);
            end
            else
            begin
                mix_idx_next = mix_idx_reg + AW'(1);
            end
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                counter_next  = counter_reg + 8'd1;
                byte_pos_next = '0;
                key_idx_next  = '0;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + 16'd1;
                // The key index follows pos mod N, including the 16-bit wrap.
                if (byte_pos_reg == 16'hFFFF || key_idx_reg == IDX_LAST)
                begin
                    key_idx_next = '0;
                end
                else
                begin
                    key_idx_next = key_idx_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_valid_a_reg <= 1'b0;
            rd_valid_b_reg <= 1'b0;
            absorb_pos_reg <= '0;
            key_idx_reg    <= '0;
            byte_pos_reg   <= '0;
            counter_reg    <= '0;
            mix_idx_reg    <= '0;
            mix_round_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            absorb_pos_reg <= absorb_pos_next;
            key_idx_reg    <= key_idx_next;
            byte_pos_reg   <= byte_pos_next;
            counter_reg    <= counter_next;
            mix_idx_reg    <= mix_idx_next;
            mix_round_reg  <= mix_round_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.rd_en)
            begin
                rd_valid_a_reg <= valid_reg[raddr_a];
                rd_valid_b_reg <= valid_reg[mix_nb];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.out_load)
        begin
            out_byte_reg <= value_reg ^ key_a ^ keystream;
            out_last_reg <= last_reg;
        end
    end

    assign sts.mix_elem_last  = (mix_idx_reg == IDX_LAST);
    assign sts.mix_round_last = (mix_round_reg == ROUND_LAST);
    assign sts.out_free       = out_free;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    `XKS_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, (!out_valid_reg || out_ready), "output word overwritten before it was taken")
    `XKS_ASSERT_ALWAYS(a_absorb_range, (int'(absorb_pos_reg) < KEY_BYTES), "absorb position left the key range")
    `XKS_ASSERT_ALWAYS(a_key_idx_range, (int'(key_idx_reg) < KEY_BYTES), "key index left the key range")

endmodule

// ----- design/xor_keystream_packet_scrambler_core.sv -----
// Packet scrambler with an internal key store of KEY_BYTES bytes.
// Input words arrive on the s_axis channel: tuser selects the kind of word
// (clear key, absorb a secret byte, mix the key, or data byte), tdata carries
// the byte and tlast marks the last data byte of a packet. Each data byte
// leaves on the m_axis channel XORed with the key and a per-byte keystream;
// the other kinds produce no output word. Scrambling and unscrambling are the
// same operation.
// One word is processed at a time. A clear is done as it is accepted; an
// absorb or a data byte first reads its entry from the key memory, and a
// mix reads and writes each key entry in turn for MIX_ROUNDS rounds. The
// registered memory read and the read-then-write sequence of each key update
// set these steps. A data byte reaches m_axis through that read and the
// output register, which lets the next input word be accepted while a result
// still waits. If the receiver stalls, a data byte waits in the core until
// the output register is free, and no further word is accepted meanwhile.
// After reset the key reads as all zero through per-entry valid flags, so no
// clearing pass is needed; the counters and positions also start at zero.
module xor_keystream_packet_scrambler_core #(
    parameter int KEY_BYTES  = 32,
    parameter int MIX_ROUNDS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // value[7:0]
    input  logic [1:0] s_axis_tuser,   // kind[1:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte[7:0]
    output logic       m_axis_tlast
);

    xks_pkg::cmd_t    cmd;
    xks_pkg::status_t sts;
    xks_pkg::kind_t   in_kind;

    assign in_kind = xks_pkg::kind_t'(s_axis_tuser);

    // The controller sequences each word; the datapath holds key and counters.
    xks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (in_kind),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    xks_datapath #(
        .KEY_BYTES  (KEY_BYTES),
        .MIX_ROUNDS (MIX_ROUNDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_value  (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- test/xks_stream_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels of the scrambler core, keeps its own copy of
// the key store, packet counter and byte position, and checks every output
// word against the byte predicted for the oldest accepted data word.
module xks_stream_checker #(
    parameter int KEY_BYTES  = 32,
    parameter int MIX_ROUNDS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // value[7:0]
    input  logic [1:0] s_axis_tuser,   // kind[1:0]
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // out_byte[7:0]
    input  logic       m_axis_tlast,
    output int         mismatch_count,
    output int         pending_bytes,
    output int         bytes_checked,
    output int         packets_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } scrambled_t;

    logic [7:0] key_copy [KEY_BYTES];
    logic [7:0] pkt_counter;
    logic [15:0] byte_pos;
    int         absorb_pos;
    scrambled_t expected_bytes [$];

    initial begin
        mismatch_count  = 0;
        pending_bytes   = 0;
        bytes_checked   = 0;
        packets_checked = 0;
    end

    function automatic logic [7:0] rotl3(input logic [7:0] b);
        return {b[7-xks_pkg::ROTATE:0], b[7:8-xks_pkg::ROTATE]};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Mixing works in place: entries already updated in this round feed
    // later entries of the same round.
    task automatic mix_key_copy();
        for (int r = 0; r < MIX_ROUNDS; r++)
            for (int i = 0; i < KEY_BYTES; i++)
                key_copy[i] = rotl3(key_copy[i])
                              ^ key_copy[(i + xks_pkg::MIX_NEIGHBOR) % KEY_BYTES];
    endtask

    // The keystream byte is the low byte of counter XOR position * golden ratio.
    function automatic scrambled_t scramble_byte(input logic [7:0] v, input logic l);
        logic [31:0] stream;
        scrambled_t  res;
        stream   = {24'd0, pkt_counter} ^ (32'(byte_pos) * xks_pkg::GOLDEN);
        res.data = v ^ key_copy[byte_pos % KEY_BYTES] ^ stream[7:0];
        res.last = l;
        return res;
    endfunction

    task automatic apply_word(input xks_pkg::kind_t k, input logic [7:0] v,
                              input logic l);
        case (k)
            xks_pkg::KIND_CLEAR:
            begin
                foreach (key_copy[i])
                    key_copy[i] = 8'd0;
                absorb_pos  = 0;
                pkt_counter = 8'd0;
                byte_pos    = 16'd0;
            end
            xks_pkg::KIND_ABSORB:
            begin
                key_copy[absorb_pos] = key_copy[absorb_pos] ^ v;
                absorb_pos = (absorb_pos + 1 == KEY_BYTES) ? 0 : absorb_pos + 1;
            end
            xks_pkg::KIND_MIX:
            begin
                mix_key_copy();
            end
            default:
            begin
                expected_bytes.push_back(scramble_byte(v, l));
                if (l)
                begin
                    pkt_counter = pkt_counter + 8'd1;
                    byte_pos    = 16'd0;
                end
                else
                begin
                    byte_pos = byte_pos + 16'd1;
                end
            end
        endcase
    endtask

    task automatic check_result(input logic [7:0] got_data, input logic got_last);
        scrambled_t want;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("output word %h last %b with nothing expected",
                                      got_data, got_last));
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got_data !== want.data)
                report_mismatch($sformatf("word %0d: byte %h, expected %h",
                                          bytes_checked, got_data, want.data));
            if (got_last !== want.last)
                report_mismatch($sformatf("word %0d: last %b, expected %b",
                                          bytes_checked, got_last, want.last));
            bytes_checked++;
            if (want.last)
                packets_checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (key_copy[i])
                key_copy[i] = 8'd0;
            absorb_pos  = 0;
            pkt_counter = 8'd0;
            byte_pos    = 16'd0;
            expected_bytes.delete();
            pending_bytes = 0;
        end
        else
        begin
            // A result never leaves in the cycle in which its word is taken,
            // so the output side is handled first.
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                apply_word(xks_pkg::kind_t'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
            pending_bytes = expected_bytes.size();
        end
    end

endmodule

// ----- test/xor_keystream_packet_scrambler_core_tb.sv -----
`timescale 1ns / 100ps

// Drives the scrambler core with key loading, mixing and packet words,
// throttles both channels, and gives the verdict. All prediction and
// comparison happens in the stream checker that sits beside the core.
module xor_keystream_packet_scrambler_core_tb;

    localparam int KEY_BYTES  = 32;
    localparam int MIX_ROUNDS = 4;

    // Minimum number of random words to send after the directed part.
    localparam int RANDOM_ITEMS = 800;

    // A mix is the slowest word the core handles.
    localparam int MIX_CYCLES = 2 * MIX_ROUNDS * KEY_BYTES + 1;

    // Cycles to wait after the last result so that a late or stray word
    // still shows up, even behind a mix that was still running.
    localparam int SETTLE_CYCLES = MIX_CYCLES + 16;

    // Roughly 800 to 2,200 words in total. The slowest correct run gives each
    // word the longest sender gap and, were every word a mix, its full mix
    // length; data words also wait on the receiver. The limit lies well above.
    localparam int CYCLE_LIMIT = 3000000;

    // Receiver throttling modes.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_HEAVY
    } rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // value[7:0]
    logic [1:0] s_axis_tuser;   // kind[1:0]
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // out_byte[7:0]
    logic       m_axis_tlast;

    int mismatch_count;
    int pending_bytes;
    int bytes_checked;
    int packets_checked;

    int cycle_count = 0;
    int burst_left  = 0;
    int words_sent  = 0;
    int mixes_sent  = 0;
    int clears_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_keystream_packet_scrambler_core #(
        .KEY_BYTES (KEY_BYTES),
        .MIX_ROUNDS(MIX_ROUNDS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    xks_stream_checker #(
        .KEY_BYTES (KEY_BYTES),
        .MIX_ROUNDS(MIX_ROUNDS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .pending_bytes  (pending_bytes),
        .bytes_checked  (bytes_checked),
        .packets_checked(packets_checked)
    );

    // The watchdog ends a hung run. It is the only other place that stops
    // the simulation.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d words still expected.",
                 cycle_count, pending_bytes);
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver changes its throttling mode after each random span: fully
    // open stretches, random stalls, a fixed stall rhythm, and rare spells of
    // heavy back-pressure that keep a result waiting inside the core.
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       phase;
        m_axis_tready = 1'b0;
        phase = 0;
        forever
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: mode = RX_ALWAYS;
                3, 4:    mode = RX_RANDOM;
                5, 6:    mode = RX_PERIODIC;
                default: mode = RX_HEAVY;
            endcase
            span = $urandom_range(16, 128);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    RX_ALWAYS:   m_axis_tready <= 1'b1;
                    RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_axis_tready <= (phase % 5 != 0);
                    default:     m_axis_tready <= (phase % 12 == 0);
                endcase
            end
        end
    end

    // Sends one word and returns at the falling edge after it was accepted.
    // The sender works in bursts; when a burst runs out, tvalid drops for a
    // random gap before the next word goes out. A gap of zero is never used,
    // so tvalid gets one assignment per falling edge.
    task automatic send_word(input xks_pkg::kind_t k, input logic [7:0] v,
                             input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            // One burst in five is long, which gives stretches with no gaps.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        words_sent++;
        if (k == xks_pkg::KIND_MIX)
            mixes_sent++;
        if (k == xks_pkg::KIND_CLEAR)
            clears_sent++;
    endtask

    // Holds the sender off until every expected word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending_bytes != 0);
    endtask

    task automatic send_random_word();
        send_word(xks_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    endtask

    // A packet of data words with a small chance of key traffic in between.
    // Key changes inside a packet keep the current byte position, and a clear
    // inside a packet starts a fresh one.
    task automatic send_packet(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_word(xks_pkg::kind_t'($urandom_range(0, 2)), 8'($urandom),
                          1'($urandom));
            send_word(xks_pkg::KIND_DATA, 8'($urandom), (i == len - 1));
        end
    endtask

    initial
    begin
        int session_len;
        int target;
        bit mid_drained;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = xks_pkg::KIND_CLEAR;
        s_axis_tlast  = 1'b0;
        mid_drained   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The key starts at zero, so the first packet shows
        // the keystream alone.
        send_word(xks_pkg::KIND_DATA, 8'h00, 1'b0);
        send_word(xks_pkg::KIND_DATA, 8'hFF, 1'b1);
        // An end-of-packet mark on key words has no effect.
        send_word(xks_pkg::KIND_ABSORB, 8'hA5, 1'b1);
        send_word(xks_pkg::KIND_ABSORB, 8'hFF, 1'b0);
        send_word(xks_pkg::KIND_ABSORB, 8'h00, 1'b0);
        send_word(xks_pkg::KIND_MIX, 8'hFF, 1'b1);
        send_word(xks_pkg::KIND_DATA, 8'h5A, 1'b0);
        // Absorb and mix in the middle of a packet change the key but keep
        // the position within the packet.
        send_word(xks_pkg::KIND_ABSORB, 8'h3C, 1'b0);
        send_word(xks_pkg::KIND_DATA, 8'h80, 1'b0);
        send_word(xks_pkg::KIND_MIX, 8'h00, 1'b0);
        send_word(xks_pkg::KIND_DATA, 8'h01, 1'b1);
        send_word(xks_pkg::KIND_DATA, 8'h7F, 1'b0);
        // A clear in the middle of a packet starts the next byte at zero.
        send_word(xks_pkg::KIND_CLEAR, 8'hFF, 1'b1);
        send_word(xks_pkg::KIND_DATA, 8'hAA, 1'b1);
        // Mixing an all-zero key leaves it all zero.
        send_word(xks_pkg::KIND_MIX, 8'h00, 1'b0);
        send_word(xks_pkg::KIND_DATA, 8'h55, 1'b1);
        drain();

        // Random part. Most sessions are well formed: often clear, load a key of
        // random length (past the key size at times, so the load position
        // wraps), usually mix, then a few packets. The rest is noise.
        target = words_sent + RANDOM_ITEMS;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_word(xks_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom));
                session_len = $urandom_range(1, KEY_BYTES + 8);
                repeat (session_len)
                    send_word(xks_pkg::KIND_ABSORB, 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 9) < 7)
                    send_word(xks_pkg::KIND_MIX, 8'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 6))
                    send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                            : $urandom_range(1, 40));
            end
            else
            begin
                repeat ($urandom_range(5, 20))
                    send_random_word();
            end

            // Halfway through, let everything drain once more.
            if (!mid_drained && words_sent >= target - RANDOM_ITEMS / 2)
            begin
                drain();
                mid_drained = 1'b1;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d words with %0d key clears and %0d key mixes in %0d cycles.",
                 words_sent, clears_sent, mixes_sent, cycle_count);
        $display("Checked %0d output words in %0d packets under random back-pressure.",
                 bytes_checked, packets_checked);
        if (mismatch_count == 0 && pending_bytes == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d words never arrived.",
                     mismatch_count, pending_bytes);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
